[hdl/servo_position_reply_parser_assert.svh]
// assertion macros for the servo reply parser
// each macro takes a label, an antecedent and a consequent sampled on i_clk
// the assertions are disabled while i_rst_n is low
`ifndef SERVO_POSITION_REPLY_PARSER_ASSERT_SVH
`define SERVO_POSITION_REPLY_PARSER_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define SPRP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("servo reply parser: assertion failed");
// next-cycle implication
`define SPRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("servo reply parser: assertion failed");
`else
`define SPRP_ASSERT_SAME(label, ante, cons)
`define SPRP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hdl/sprp_pkg.sv]
package sprp_pkg;

    // parse phase of the current reply
    typedef enum logic [1:0] {
        PH_SEEK = 2'd0,
        PH_ID   = 2'd1,
        PH_POS  = 2'd2
    } t_phase;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_HASH   = 3'd1,
        ST_TOO_SHORT = 3'd2,
        ST_NO_ID     = 3'd3,
        ST_BAD_ID    = 3'd4,
        ST_BAD_POS   = 3'd5
    } t_status;

    // per-field leading-integer parse flags
    typedef struct packed {
        logic stop;
        logic digit;
        logic sign;
    } t_field;

    // characters of the reply framing
    localparam logic [7:0] ChHash  = 8'h23;
    localparam logic [7:0] ChP     = 8'h50;
    localparam logic [7:0] ChBang  = 8'h21;
    localparam logic [7:0] ChMinus = 8'h2D;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;

    // shortest acceptable frame, counted from '#' to '!' inclusive
    localparam logic [3:0] MinFrame = 4'd10;

    // id saturation point and position magnitude limit
    localparam logic [8:0]  IdSat    = 9'd256;
    localparam logic [31:0] PosLimit = 32'h8000_0000;

endpackage

[hdl/servo_position_reply_parser.sv]
// Servo position reply parser: takes one received character per transaction and gives one
// result transaction (status, signed 32-bit position) at each '!' that closes a reply; all
// other characters give no result. A character can be accepted in every clock cycle, and a result
// passes through one input register and one result register after its '!' is accepted; the
// input only stalls while a finished result is held by a stall on the output side.
// Assert start_req with the first character of a reply to clear any partial parse; after a
// '!' the parser clears itself. i_servo_id is compared at the closing '!'.
`include "servo_position_reply_parser_assert.svh"

module servo_position_reply_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // character input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_start_req,
    input  logic [7:0]         i_servo_id,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_position
);
    import sprp_pkg::*;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_start;
    logic [7:0]  r_in_exp_id;

    // parse state
    t_phase      r_phase,    n_phase;
    logic [3:0]  r_frame_len, n_frame_len;
    t_field      r_id_flags, n_id_flags;
    logic [8:0]  r_id_value, n_id_value;
    logic        r_id_empty, n_id_empty;
    t_field      r_pos_flags, n_pos_flags;
    logic [31:0] r_pos_mag,  n_pos_mag;
    logic        r_pos_ovf,  n_pos_ovf;

    // result register
    logic               r_out_valid;
    t_status            r_status;
    logic signed [31:0] r_position;

    // working values
    t_phase      cur_phase;
    logic [3:0]  cur_frame_len;
    t_field      cur_id_flags;
    logic [8:0]  cur_id_value;
    logic        cur_id_empty;
    t_field      cur_pos_flags;
    logic [31:0] cur_pos_mag;
    logic        cur_pos_ovf;
    logic        advance;
    logic        fire;
    logic        is_bang;
    logic        is_digit;
    logic [3:0]  digit;
    logic [11:0] id_ext;
    logic [11:0] id_prod;
    logic [35:0] pos_ext;
    logic [35:0] pos_prod;
    logic        id_bad;
    logic        pos_neg;
    logic        pos_bad;
    t_status     res_status;
    logic [31:0] res_position;

    // handshake control
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    // character classification
    assign is_bang  = (r_in_byte == ChBang);
    assign is_digit = (r_in_byte >= ChZero) && (r_in_byte <= ChNine);
    assign digit    = r_in_byte[3:0];

    // decimal accumulation by shift-add
    assign id_ext   = {3'b000, cur_id_value};
    assign id_prod  = (id_ext << 3) + (id_ext << 1) + {8'h00, digit};
    assign pos_ext  = {4'h0, cur_pos_mag};
    assign pos_prod = (pos_ext << 3) + (pos_ext << 1) + {32'h0, digit};

    // start request clears the state before the character is taken
    always_comb begin
        if (r_in_start) begin
            cur_phase     = PH_SEEK;
            cur_frame_len = '0;
            cur_id_flags  = '0;
            cur_id_value  = '0;
            cur_id_empty  = 1'b1;
            cur_pos_flags = '0;
            cur_pos_mag   = '0;
            cur_pos_ovf   = 1'b0;
        end else begin
            cur_phase     = r_phase;
            cur_frame_len = r_frame_len;
            cur_id_flags  = r_id_flags;
            cur_id_value  = r_id_value;
            cur_id_empty  = r_id_empty;
            cur_pos_flags = r_pos_flags;
            cur_pos_mag   = r_pos_mag;
            cur_pos_ovf   = r_pos_ovf;
        end
    end

    // field checks at the closing character
    assign id_bad  = !cur_id_flags.digit || (cur_id_value > 9'd255) ||
                     (cur_id_flags.sign && (cur_id_value != 9'd0)) ||
                     (cur_id_value != {1'b0, r_in_exp_id});
    assign pos_neg = cur_pos_flags.sign;
    assign pos_bad = !cur_pos_flags.digit || cur_pos_ovf ||
                     (!pos_neg && (cur_pos_mag == PosLimit));

    // next parse state and result
    always_comb begin
        n_phase     = cur_phase;
        n_frame_len = cur_frame_len;
        n_id_flags  = cur_id_flags;
        n_id_value  = cur_id_value;
        n_id_empty  = cur_id_empty;
        n_pos_flags = cur_pos_flags;
        n_pos_mag   = cur_pos_mag;
        n_pos_ovf   = cur_pos_ovf;
        res_status  = ST_OK;
        res_position = '0;

        if ((cur_phase != PH_SEEK) && (cur_frame_len < MinFrame)) begin
            n_frame_len = cur_frame_len + 4'd1;
        end

        if (is_bang) begin
            priority if (cur_phase == PH_SEEK) begin
                res_status = ST_NO_HASH;
            end else if (n_frame_len < MinFrame) begin
                res_status = ST_TOO_SHORT;
            end else if ((cur_phase == PH_ID) || cur_id_empty) begin
                res_status = ST_NO_ID;
            end else if (id_bad) begin
                res_status = ST_BAD_ID;
            end else if (pos_bad) begin
                res_status = ST_BAD_POS;
            end else begin
                res_status   = ST_OK;
                res_position = pos_neg ? (32'h0 - cur_pos_mag) : cur_pos_mag;
            end
            // a closed reply leaves the parser clear
            n_phase     = PH_SEEK;
            n_frame_len = '0;
            n_id_flags  = '0;
            n_id_value  = '0;
            n_id_empty  = 1'b1;
            n_pos_flags = '0;
            n_pos_mag   = '0;
            n_pos_ovf   = 1'b0;
        end else begin
            unique case (cur_phase)
                PH_SEEK: begin
                    if (r_in_byte == ChHash) begin
                        n_phase     = PH_ID;
                        n_frame_len = 4'd1;
                    end
                end
                PH_ID: begin
                    if (r_in_byte == ChP) begin
                        n_phase = PH_POS;
                    end else begin
                        n_id_empty = 1'b0;
                        if (!cur_id_flags.stop) begin
                            if (is_digit) begin
                                n_id_flags.digit = 1'b1;
                                n_id_value = (id_prod > {3'b000, IdSat}) ? IdSat : id_prod[8:0];
                            end else if ((cur_id_flags == '0) && (r_in_byte == ChMinus)) begin
                                n_id_flags.sign = 1'b1;
                            end else begin
                                n_id_flags.stop = 1'b1;
                            end
                        end
                    end
                end
                PH_POS: begin
                    if (!cur_pos_flags.stop) begin
                        if (is_digit) begin
                            n_pos_flags.digit = 1'b1;
                            if (pos_prod > {4'h0, PosLimit}) begin
                                n_pos_ovf = 1'b1;
                                n_pos_mag = PosLimit;
                            end else begin
                                n_pos_mag = pos_prod[31:0];
                            end
                        end else if ((cur_pos_flags == '0) && (r_in_byte == ChMinus)) begin
                            n_pos_flags.sign = 1'b1;
                        end else begin
                            n_pos_flags.stop = 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = PH_SEEK;
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte   <= i_rx_byte;
            r_in_start  <= i_start_req;
            r_in_exp_id <= i_servo_id;
        end
    end

    // parse state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SEEK;
            r_frame_len <= '0;
            r_id_flags  <= '0;
            r_id_value  <= '0;
            r_id_empty  <= 1'b1;
            r_pos_flags <= '0;
            r_pos_mag   <= '0;
            r_pos_ovf   <= 1'b0;
        end else if (fire) begin
            r_phase     <= n_phase;
            r_frame_len <= n_frame_len;
            r_id_flags  <= n_id_flags;
            r_id_value  <= n_id_value;
            r_id_empty  <= n_id_empty;
            r_pos_flags <= n_pos_flags;
            r_pos_mag   <= n_pos_mag;
            r_pos_ovf   <= n_pos_ovf;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && is_bang) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && is_bang) begin
            r_status   <= res_status;
            r_position <= res_position;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_position  = r_position;

    // checks
    `SPRP_ASSERT_NEXT(a_bang_gives_result, fire && is_bang, r_out_valid)
    `SPRP_ASSERT_SAME(a_pos_zero_on_error, r_out_valid && (r_status != ST_OK), r_position == 0)
    `SPRP_ASSERT_SAME(a_seek_has_no_length, r_phase == PH_SEEK, r_frame_len == 4'd0)
    `SPRP_ASSERT_SAME(a_length_saturates, 1'b1, r_frame_len <= MinFrame)
    `SPRP_ASSERT_SAME(a_id_saturates, 1'b1, r_id_value <= IdSat)

endmodule

[dv/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sprp_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_TAIL  = 8;
    localparam int LONG_HOLD   = 300;

    // one reply result as the block should give it
    typedef struct packed {
        t_status     status;
        logic [31:0] pos;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte = '0;
    logic        i_start_req = 1'b0;
    logic [7:0]  i_servo_id = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_status;
    logic signed [31:0] o_position;

    // expected results in arrival order
    t_reply      replies_due[$];
    logic [7:0]  frame_bytes[$];

    int          errors = 0;
    int          chars_taken = 0;
    int          results_checked = 0;
    int          status_count[6];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_req = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    // parse state of the reply tracker
    t_phase      reply_phase;
    logic [3:0]  reply_len;
    t_field      id_flags;
    t_field      pos_flags;
    logic [8:0]  id_accum;
    logic        id_blank;
    logic [31:0] pos_accum;
    logic        pos_over;

    servo_position_reply_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_rx_byte     (i_rx_byte),
        .i_start_req   (i_start_req),
        .i_servo_id    (i_servo_id),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_position    (o_position)
    );

    always #10 i_clk = ~i_clk;

    task automatic clear_reply_tracker();
        reply_phase = PH_SEEK;
        reply_len   = '0;
        id_flags    = '0;
        pos_flags   = '0;
        id_accum    = '0;
        id_blank    = 1'b1;
        pos_accum   = '0;
        pos_over    = 1'b0;
    endtask

    // append one character to the frame being built
    task automatic add_byte(input logic [7:0] b);
        frame_bytes = {frame_bytes, b};
    endtask

    // leading-integer scan of one field character
    task automatic scan_field_char(inout t_field f, input logic [7:0] c, output logic is_digit);
        is_digit = 1'b0;
        if (!f.stop) begin
            if (c >= ChZero && c <= ChNine) begin
                f.digit  = 1'b1;
                is_digit = 1'b1;
            end else if (f == '0 && c == ChMinus) begin
                f.sign = 1'b1;
            end else begin
                f.stop = 1'b1;
            end
        end
    endtask

    // advance the tracker by one accepted character, queueing a result at '!'
    task automatic track_reply_char(input logic [7:0] c, input logic start, input logic [7:0] want_id);
        logic        is_digit;
        logic [11:0] id_next;
        logic [35:0] pos_next;
        logic [31:0] pos_cap;
        t_reply      r;
        if (start)
            clear_reply_tracker();
        if (reply_phase != PH_SEEK && reply_len < MinFrame)
            reply_len = reply_len + 4'd1;
        if (c == ChBang) begin
            r.pos = '0;
            pos_cap = pos_flags.sign ? PosLimit : PosLimit - 32'd1;
            if (reply_phase == PH_SEEK) begin
                r.status = ST_NO_HASH;
            end else if (reply_len < MinFrame) begin
                r.status = ST_TOO_SHORT;
            end else if (reply_phase == PH_ID || id_blank) begin
                r.status = ST_NO_ID;
            end else if (!id_flags.digit || id_accum > 9'd255 ||
                         (id_flags.sign && id_accum != 9'd0) || id_accum != {1'b0, want_id}) begin
                r.status = ST_BAD_ID;
            end else if (!pos_flags.digit || pos_over || pos_accum > pos_cap) begin
                r.status = ST_BAD_POS;
            end else begin
                r.status = ST_OK;
                r.pos    = pos_flags.sign ? (32'd0 - pos_accum) : pos_accum;
            end
            replies_due = {replies_due, r};
            clear_reply_tracker();
        end else begin
            case (reply_phase)
                PH_SEEK: begin
                    if (c == ChHash) begin
                        reply_phase = PH_ID;
                        reply_len   = 4'd1;
                    end
                end
                PH_ID: begin
                    if (c == ChP) begin
                        reply_phase = PH_POS;
                    end else begin
                        id_blank = 1'b0;
                        scan_field_char(id_flags, c, is_digit);
                        if (is_digit) begin
                            id_next  = 12'(id_accum) * 12'd10 + 12'(c - ChZero);
                            id_accum = (id_next > 12'(IdSat)) ? IdSat : id_next[8:0];
                        end
                    end
                end
                default: begin
                    scan_field_char(pos_flags, c, is_digit);
                    if (is_digit) begin
                        pos_next = 36'(pos_accum) * 36'd10 + 36'(c - ChZero);
                        if (pos_next > 36'(PosLimit)) begin
                            pos_over  = 1'b1;
                            pos_accum = PosLimit;
                        end else begin
                            pos_accum = pos_next[31:0];
                        end
                    end
                end
            endcase
        end
    endtask

    // offer one character and wait for its transaction
    task automatic send_char(input logic [7:0] c, input logic start, input logic [7:0] want_id);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_rx_byte     <= c;
        i_start_req   <= start;
        i_servo_id    <= want_id;
        do
            @(posedge i_clk);
        while (o_in_stall);
        track_reply_char(c, start, want_id);
        chars_taken++;
    endtask

    task automatic send_frame(input logic [7:0] want_id, input logic start);
        for (int i = 0; i < frame_bytes.size(); i++)
            send_char(frame_bytes[i], start && (i == 0), want_id);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic push_number(input longint v, input int zeros);
        longint mag;
        mag = (v < 0) ? -v : v;
        if (v < 0)
            add_byte(ChMinus);
        repeat (zeros) add_byte(ChZero);
        push_text($sformatf("%0d", mag));
    endtask

    task automatic send_text(input string s, input logic [7:0] want_id, input logic start);
        frame_bytes.delete();
        push_text(s);
        send_frame(want_id, start);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == ChBang);
        return b;
    endfunction

    // sender stops until every result is back
    task automatic pause_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (replies_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic wait_replies_done();
        pause_for_results();
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    // mostly well-formed replies with random content, some broken
    task automatic compose_random_reply(output logic [7:0] want_id, output logic start);
        int     pick;
        int     sv;
        longint v;
        frame_bytes.delete();
        want_id = 8'($urandom_range(0, 255));
        start   = ($urandom_range(99) < 90);
        // leading noise
        pick = $urandom_range(99);
        if (pick < 15) begin
            repeat ($urandom_range(1, 3)) add_byte(plain_byte());
        end else if (pick < 18) begin
            repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(99) >= 3)
            add_byte(ChHash);
        // id field
        pick = $urandom_range(99);
        if (pick < 70) begin
            push_number(want_id, $urandom_range(0, 2));
        end else if (pick < 75) begin
            add_byte(ChMinus);
            push_number(0, $urandom_range(0, 1));
            if ($urandom_range(1))
                want_id = '0;
        end else if (pick < 80) begin
            push_number($urandom_range(0, 999), 0);
        end else if (pick < 84) begin
            // empty id
        end else if (pick < 88) begin
            add_byte(ChMinus);
            if ($urandom_range(1))
                push_number($urandom_range(1, 300), 0);
        end else if (pick < 92) begin
            add_byte(plain_byte());
            push_number(want_id, 0);
        end else begin
            push_number(want_id, 0);
            repeat ($urandom_range(1, 3)) add_byte(plain_byte());
        end
        if ($urandom_range(99) < 96)
            add_byte(ChP);
        // position field
        pick = $urandom_range(99);
        if (pick < 55) begin
            v = $urandom_range(0, 4000);
            if ($urandom_range(1))
                v = -v;
            push_number(v, $urandom_range(0, 7));
        end else if (pick < 70) begin
            sv = $urandom();
            push_number(sv, $urandom_range(0, 2));
        end else if (pick < 78) begin
            case ($urandom_range(0, 5))
                0: v = -64'sd2147483648;
                1: v = 64'sd2147483647;
                2: v = 64'sd2147483648;
                3: v = -64'sd2147483649;
                4: v = 64'sd2147483650;
                default: v = -64'sd2147483647;
            endcase
            push_number(v, $urandom_range(0, 2));
        end else if (pick < 84) begin
            if ($urandom_range(1))
                add_byte(ChMinus);
            add_byte(ChZero + 8'($urandom_range(1, 9)));
            repeat ($urandom_range(10, 13)) add_byte(ChZero + 8'($urandom_range(0, 9)));
        end else if (pick < 88) begin
            if ($urandom_range(1))
                add_byte(ChMinus);
            repeat ($urandom_range(0, 8)) add_byte(plain_byte());
        end else if (pick < 94) begin
            push_number($urandom_range(0, 99999), 0);
            repeat ($urandom_range(1, 4)) add_byte(plain_byte());
        end else begin
            repeat ($urandom_range(0, 9)) add_byte(plain_byte());
        end
        if ($urandom_range(99) < 97)
            add_byte(ChBang);
    endtask

    // every status and the corner cases of both fields
    task automatic test_directed_replies();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_text("#1P1500!", 8'd1, 1'b1);
        send_text("xx#001P001500!", 8'd1, 1'b1);
        send_text("!", 8'd0, 1'b1);
        send_text("#0123456789!", 8'd0, 1'b1);
        send_text("#P123456789!", 8'd0, 1'b1);
        send_text("#-0P0000001!", 8'd0, 1'b1);
        send_text("#-P12345678!", 8'd0, 1'b1);
        send_text("#7P12345678!", 8'd8, 1'b1);
        send_text("#256P1000000!", 8'd0, 1'b1);
        send_text("#255P-2147483648!", 8'd255, 1'b1);
        send_text("#1P2147483647!", 8'd1, 1'b1);
        send_text("#1P2147483648!", 8'd1, 1'b1);
        send_text("#1P-2147483649!", 8'd1, 1'b1);
        send_text("#1P99999999999!", 8'd1, 1'b1);
        send_text("#1P-abcdefg!", 8'd1, 1'b1);
        send_text("#1#P1234567P8!", 8'd1, 1'b1);
        // restart in the middle of a reply
        send_text("#12P3", 8'd12, 1'b1);
        send_text("#5P12345678!", 8'd5, 1'b1);
        // next reply without a start flag
        send_text("#9P00000042!", 8'd9, 1'b0);
        // extreme byte values as noise and as a field terminator
        frame_bytes.delete();
        add_byte(8'h00);
        add_byte(8'hFF);
        push_text("#4P0001234");
        add_byte(8'hAA);
        add_byte(ChBang);
        send_frame(8'd4, 1'b1);
        wait_replies_done();
    endtask

    // long output hold while characters keep coming, then a full pause
    task automatic test_output_hold();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req = LONG_HOLD;
        repeat (24) send_char(ChBang, 1'b0, 8'd0);
        send_text("#33P-000777!", 8'd33, 1'b1);
        send_text("#200P0000065535!", 8'd200, 1'b1);
        pause_for_results();
        send_text("#17P000000-5!", 8'd17, 1'b1);
        wait_replies_done();
    endtask

    task automatic test_random_replies(input int n_chars, input int idle_pct, input int stall_pct);
        int         first;
        logic [7:0] want_id;
        logic       start;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        first = chars_taken;
        while (chars_taken - first < n_chars) begin
            compose_random_reply(want_id, start);
            send_frame(want_id, start);
            if ($urandom_range(99) < 4)
                pause_for_results();
        end
        wait_replies_done();
    endtask

    // receiver: random stall, or a counted long hold when asked
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_reply want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (replies_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got status %0d position %0d",
                         $time, o_status, o_position);
            end else begin
                want = replies_due.pop_front();
                results_checked++;
                status_count[want.status]++;
                if (o_status !== want.status) begin
                    errors++;
                    $display("%0t: status mismatch, expected %0d got %0d",
                             $time, want.status, o_status);
                end
                if (o_position !== want.pos) begin
                    errors++;
                    $display("%0t: position mismatch, expected %0d got %0d",
                             $time, $signed(want.pos), o_position);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        clear_reply_tracker();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_replies();
        test_output_hold();
        test_random_replies(240, 0, 0);
        test_random_replies(240, 88, 0);
        test_random_replies(240, 0, 88);
        test_random_replies(240, 19, 19);

        if (replies_due.size() != 0) begin
            errors += replies_due.size();
            $display("%0t: %0d expected results never arrived", $time, replies_due.size());
        end
        $display("sent %0d characters, checked %0d results under four idle and stall mixes",
                 chars_taken, results_checked);
        $display("ok %0d, no hash %0d, short %0d, no id %0d, bad id %0d, bad position %0d",
                 status_count[0], status_count[1], status_count[2],
                 status_count[3], status_count[4], status_count[5]);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
